// ----- hdl/sawarq_pkg.sv -----
package sawarq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int OP_W = 3;
  localparam int TAG_W = 16;
  localparam int MODE_W = 2;
  localparam int QCOUNT_W = 5;

  localparam logic [OP_W-1:0] OP_DATA    = 3'd0;
  localparam logic [OP_W-1:0] OP_ACK     = 3'd1;
  localparam logic [OP_W-1:0] OP_NACK    = 3'd2;
  localparam logic [OP_W-1:0] OP_TXDONE  = 3'd3;
  localparam logic [OP_W-1:0] OP_TIMEOUT = 3'd4;

  localparam logic [MODE_W-1:0] MODE_READY   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SENDING = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WAITING = 2'd2;

  typedef struct packed {
    logic             push;
    logic             pop;
    logic [TAG_W-1:0] push_tag;
  } fifo_ctrl_t;

  typedef struct packed {
    logic [TAG_W-1:0]   head_tag;
    logic [COUNT_W-1:0] count;
    logic [COUNT_W-1:0] count_next;
  } fifo_stat_t;

endpackage

// ----- hdl/sawarq_fifo.sv -----
module sawarq_fifo
  import sawarq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  fifo_ctrl_t ctrl,
  output fifo_stat_t stat
);

  logic [TAG_W-1:0]   tags [QUEUE_DEPTH];
  logic [PTR_W-1:0]   head;
  logic [PTR_W-1:0]   tail;
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_next;
  logic [PTR_W-1:0]   head_next;
  logic [PTR_W-1:0]   tail_next;

  assign head_next = (head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
  assign tail_next = (tail == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail + 1'b1;

  always_comb begin
    count_next = count;
    if (ctrl.push && !ctrl.pop) begin
      count_next = count + 1'b1;
    end else if (ctrl.pop && !ctrl.push) begin
      count_next = count - 1'b1;
    end
  end

  // a full queue may push and pop together: the head is read before the write lands
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      tags[tail] <= ctrl.push_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (ctrl.pop) begin
        head <= head_next;
      end
      if (ctrl.push) begin
        tail <= tail_next;
      end
      count <= count_next;
    end
  end

  assign stat.head_tag   = tags[head];
  assign stat.count      = count;
  assign stat.count_next = count_next;

endmodule

// ----- hdl/stop_and_wait_arq_sender.sv -----
// stop-and-wait arq transmit controller
// input channel: in_valid / in_stall carry one event per item, operation
// (data, ack, nack, transmission done, timeout) and packet_tag
// output channel: out_valid / out_stall carry one result per event: the
// packet sent if any, retransmission flag, mode, queue fill, drop and error flags
// an event is captured in the input register, is resolved against the
// mode, outstanding tag and 16-entry tag queue, and lands in the result
// register; one event per cycle sustained while out_stall stays low, set
// by the single state update per event
// reset empties the queue, clears the outstanding tag and returns to ready
// when the receiver stalls, the result holds and the input register holds
// its event; in_stall rises only once both stages are occupied
module stop_and_wait_arq_sender
  import sawarq_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [OP_W-1:0]     operation,
  input  logic [TAG_W-1:0]    packet_tag,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                send_valid,
  output logic [TAG_W-1:0]    send_tag,
  output logic                is_retransmission,
  output logic [MODE_W-1:0]   sender_mode,
  output logic [QCOUNT_W-1:0] queued_count,
  output logic                dropped,
  output logic                protocol_error
);

  logic              in_full;
  logic [OP_W-1:0]   in_op;
  logic [TAG_W-1:0]  in_tag;
  logic              advance;

  logic [MODE_W-1:0] mode;
  logic [MODE_W-1:0] mode_next;
  logic [TAG_W-1:0]  out_tag;
  logic [TAG_W-1:0]  out_tag_next;
  logic              out_tag_valid;
  logic              out_tag_valid_next;

  logic              sent;
  logic [TAG_W-1:0]  stag;
  logic              retx;
  logic              drop;
  logic              err;
  logic              push;
  logic              pop;

  fifo_ctrl_t        fifo_ctrl;
  fifo_stat_t        fifo_stat;

  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_op  <= operation;
      in_tag <= packet_tag;
    end
  end

  always_comb begin
    sent               = 1'b0;
    stag               = '0;
    retx               = 1'b0;
    drop               = 1'b0;
    err                = 1'b0;
    push               = 1'b0;
    pop                = 1'b0;
    mode_next          = mode;
    out_tag_next       = out_tag;
    out_tag_valid_next = out_tag_valid;
    unique case (in_op) inside
      OP_DATA: begin
        if (mode == MODE_READY) begin
          sent = 1'b1;
          if (fifo_stat.count == '0) begin
            stag = in_tag;
          end else begin
            // keep order: the head goes out, the new tag joins the tail
            stag = fifo_stat.head_tag;
            pop  = 1'b1;
            push = 1'b1;
          end
        end else if (fifo_stat.count == COUNT_W'(QUEUE_DEPTH)) begin
          drop = 1'b1;
        end else begin
          push = 1'b1;
        end
      end
      OP_ACK: begin
        if (!out_tag_valid) begin
          err = 1'b1;
        end else begin
          out_tag_valid_next = 1'b0;
          mode_next          = MODE_READY;
          if (fifo_stat.count != '0) begin
            stag = fifo_stat.head_tag;
            pop  = 1'b1;
            sent = 1'b1;
          end
        end
      end
      OP_NACK, OP_TIMEOUT: begin
        if (!out_tag_valid) begin
          err = 1'b1;
        end else begin
          stag = out_tag;
          sent = 1'b1;
          retx = 1'b1;
        end
      end
      OP_TXDONE: begin
        if (mode == MODE_SENDING) begin
          mode_next = MODE_WAITING;
        end
      end
      default: begin
      end
    endcase
    if (sent) begin
      out_tag_next       = stag;
      out_tag_valid_next = 1'b1;
      mode_next          = MODE_SENDING;
    end
  end

  assign fifo_ctrl.push     = push && advance;
  assign fifo_ctrl.pop      = pop && advance;
  assign fifo_ctrl.push_tag = in_tag;

  sawarq_fifo u_fifo (
    .clk  (clk),
    .rst  (rst),
    .ctrl (fifo_ctrl),
    .stat (fifo_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_READY;
      out_tag       <= '0;
      out_tag_valid <= 1'b0;
    end else if (advance) begin
      mode          <= mode_next;
      out_tag       <= out_tag_next;
      out_tag_valid <= out_tag_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      send_valid        <= sent;
      send_tag          <= stag;
      is_retransmission <= retx;
      sender_mode       <= mode_next;
      queued_count      <= QCOUNT_W'(fifo_stat.count_next);
      dropped           <= drop;
      protocol_error    <= err;
    end
  end

endmodule
